@@ sv/swlru_pkg.sv @@
// types and constants shared by the size weighted lru index
// no dependencies
`default_nettype none
package swlru_pkg;

  typedef enum logic [2:0] {
    ACT_RESERVE  = 3'd0,
    ACT_REGISTER = 3'd1,
    ACT_TOUCH    = 3'd2,
    ACT_REMOVE   = 3'd3,
    ACT_SETCAP   = 3'd4,
    ACT_DEFLATE  = 3'd5,
    ACT_INFLATE  = 3'd6
  } act_t;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_REJECT = 2'd1;
  localparam logic [1:0] STAT_MISS   = 2'd2;

  localparam int KeyW = 64;

  typedef enum logic [1:0] {
    CO_NONE,
    CO_INSERT,
    CO_REMOVE,
    CO_FRONT
  } chain_op_t;

  typedef enum logic [1:0] {
    CC_HOLD,
    CC_PREV,
    CC_NEXT,
    CC_LOAD
  } cell_cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MATCH,
    S_ACT,
    S_INS,
    S_EVICT,
    S_OUT
  } fsm_t;

endpackage
`default_nettype wire

@@ sv/swlru_cell.sv @@
// one recency slot: valid, key and size, shifted to or from its neighbors
// depends on swlru_pkg
`default_nettype none
module swlru_cell #(
  parameter int AW = 40
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  swlru_pkg::cell_cmd_t       cmd,
  input  wire                        prev_valid,
  input  wire [swlru_pkg::KeyW-1:0]  prev_key,
  input  wire [AW-1:0]               prev_size,
  input  wire                        next_valid,
  input  wire [swlru_pkg::KeyW-1:0]  next_key,
  input  wire [AW-1:0]               next_size,
  input  wire [swlru_pkg::KeyW-1:0]  load_key,
  input  wire [AW-1:0]               load_size,
  input  wire [swlru_pkg::KeyW-1:0]  search_key,
  output logic                       valid,
  output logic [swlru_pkg::KeyW-1:0] key,
  output logic [AW-1:0]              size,
  output logic                       match
);

  logic                       valid_r, valid_nxt;
  logic [swlru_pkg::KeyW-1:0] key_r, key_nxt;
  logic [AW-1:0]              size_r, size_nxt;

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    size_nxt  = size_r;
    case (cmd)
      swlru_pkg::CC_PREV: begin
        valid_nxt = prev_valid;
        key_nxt   = prev_key;
        size_nxt  = prev_size;
      end
      swlru_pkg::CC_NEXT: begin
        valid_nxt = next_valid;
        key_nxt   = next_key;
        size_nxt  = next_size;
      end
      swlru_pkg::CC_LOAD: begin
        valid_nxt = 1'b1;
        key_nxt   = load_key;
        size_nxt  = load_size;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    size_r <= size_nxt;
  end

  assign valid = valid_r;
  assign key   = key_r;
  assign size  = size_r;
  assign match = valid_r && (key_r == search_key);

endmodule
`default_nettype wire

@@ sv/swlru_chain.sv @@
// row of recency cells, most recent at position 0, valid entries packed at the front
// depends on swlru_pkg and swlru_cell
`default_nettype none
module swlru_chain #(
  parameter int ENTRIES = 16,
  parameter int AW      = 40,
  parameter int IW      = 4
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  swlru_pkg::chain_op_t       op,
  input  wire [IW-1:0]               pos,
  input  wire [swlru_pkg::KeyW-1:0]  new_key,
  input  wire [AW-1:0]               new_size,
  input  wire [swlru_pkg::KeyW-1:0]  search_key,
  output logic [ENTRIES-1:0]         hit_vec,
  output logic [swlru_pkg::KeyW-1:0] key_at_pos,
  output logic [AW-1:0]              size_at_pos
);

  logic                       vld [ENTRIES];
  logic [swlru_pkg::KeyW-1:0] k   [ENTRIES];
  logic [AW-1:0]              sz  [ENTRIES];
  swlru_pkg::cell_cmd_t       cmd [ENTRIES];
  logic [swlru_pkg::KeyW-1:0] load_key;
  logic [AW-1:0]              load_size;

  assign key_at_pos  = k[pos];
  assign size_at_pos = sz[pos];
  assign load_key    = (op == swlru_pkg::CO_INSERT) ? new_key : key_at_pos;
  assign load_size   = (op == swlru_pkg::CO_INSERT) ? new_size : size_at_pos;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      cmd[i] = swlru_pkg::CC_HOLD;
      case (op)
        swlru_pkg::CO_INSERT: cmd[i] = (i == 0) ? swlru_pkg::CC_LOAD : swlru_pkg::CC_PREV;
        swlru_pkg::CO_REMOVE: begin
          if (i >= int'(pos)) cmd[i] = swlru_pkg::CC_NEXT;
        end
        swlru_pkg::CO_FRONT: begin
          if (i == 0) cmd[i] = swlru_pkg::CC_LOAD;
          else if (i <= int'(pos)) cmd[i] = swlru_pkg::CC_PREV;
        end
        default: ;
      endcase
    end
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    logic                       pv, nv;
    logic [swlru_pkg::KeyW-1:0] pk, nk;
    logic [AW-1:0]              ps, ns;
    if (g == 0) begin : g_head
      assign pv = 1'b0;
      assign pk = '0;
      assign ps = '0;
    end else begin : g_mid
      assign pv = vld[g-1];
      assign pk = k[g-1];
      assign ps = sz[g-1];
    end
    if (g == ENTRIES-1) begin : g_tail
      assign nv = 1'b0;
      assign nk = '0;
      assign ns = '0;
    end else begin : g_body
      assign nv = vld[g+1];
      assign nk = k[g+1];
      assign ns = sz[g+1];
    end
    swlru_cell #(.AW(AW)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd[g]),
      .prev_valid (pv),
      .prev_key   (pk),
      .prev_size  (ps),
      .next_valid (nv),
      .next_key   (nk),
      .next_size  (ns),
      .load_key   (load_key),
      .load_size  (load_size),
      .search_key (search_key),
      .valid      (vld[g]),
      .key        (k[g]),
      .size       (sz[g]),
      .match      (hit_vec[g])
    );
  end

endmodule
`default_nettype wire

@@ sv/size_weighted_lru_index.sv @@
// top level of the size weighted lru index: sequencer, counters and result buffer
// depends on swlru_pkg and swlru_chain
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall   | action, entry_key, amount, force_req, erase_hint
//  out_    | output    | out_valid/out_stall | removal fields, status, totals, last
//
// a word passes through accept, key match and action, plus an insert for register; register,
// set capacity, deflate and a reserve that is not rejected then run an eviction pass, one
// capacity eviction at a time, and the result words then load in order, held by out_stall.
// synchronous active-low reset empties the table and clears all counters.
// in_stall is high from acceptance until the last result word is loaded into the
// output register; out_stall holds that register and pauses the result stream.
`default_nettype none
module size_weighted_lru_index #(
  parameter int ENTRIES   = 16,
  parameter int SIZE_BITS = 40
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [2:0]  in_action,
  input  wire  [63:0] in_entry_key,
  input  wire  [39:0] in_amount,
  input  wire         in_force_req,
  input  wire         in_erase_hint,
  output logic        out_valid,
  input  wire         out_stall,
  output logic        out_removed_valid,
  output logic [63:0] out_removed_key,
  output logic [39:0] out_removed_size,
  output logic [31:0] out_removal_seq,
  output logic [1:0]  out_status,
  output logic        out_erased,
  output logic [43:0] out_usage,
  output logic [39:0] out_capacity_now,
  output logic [31:0] out_evicted_total,
  output logic        out_last
);

  localparam int AW   = (SIZE_BITS < 40) ? SIZE_BITS : 40;
  localparam int CW   = SIZE_BITS;
  localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNTW = $clog2(ENTRIES + 1);
  localparam int UW   = AW + CNTW;
  localparam int MAXO = ENTRIES + 1;
  localparam int NW   = $clog2(MAXO + 1);
  localparam int BIW  = $clog2(MAXO);
  localparam logic [63:0] SzMask = 64'((65'd1 << SIZE_BITS) - 65'd1);

  swlru_pkg::fsm_t state_r, state_nxt;
  logic [2:0]      act_r, act_nxt;
  logic [63:0]     key_r, key_nxt;
  logic [AW-1:0]   amt_r, amt_nxt;
  logic            force_r, force_nxt, erase_r, erase_nxt;
  logic [UW-1:0]   used_r, used_nxt;
  logic [CW-1:0]   cap_r, cap_nxt;
  logic [31:0]     rm_cnt_r, rm_cnt_nxt, ev_cnt_r, ev_cnt_nxt, seq_base_r, seq_base_nxt;
  logic [CNTW-1:0] count_r, count_nxt;
  logic            hit_r, hit_nxt;
  logic [IW-1:0]   pos_r, pos_nxt;
  logic [1:0]      status_r, status_nxt;
  logic            erased_r, erased_nxt;
  logic [UW-1:0]   sub_r, sub_nxt;
  logic [CW-1:0]   tgt_r, tgt_nxt;
  logic            minc_r, minc_nxt, en_r, en_nxt;
  logic [NW-1:0]   nres_r, nres_nxt, idx_r, idx_nxt;

  logic [63:0] buf_key  [MAXO];
  logic [AW-1:0] buf_size [MAXO];

  swlru_pkg::chain_op_t chain_op;
  logic [IW-1:0]        chain_pos;
  logic [ENTRIES-1:0]   hit_vec;
  logic [63:0]          key_at_pos;
  logic [AW-1:0]        size_at_pos;
  logic [IW-1:0]        enc_pos;

  logic          emit, emit_evict;
  logic [IW-1:0] emit_pos;
  logic [UW-1:0] size_ext, ex_w;
  logic [63:0]   used64, cap64, amt64, need64, ex64;
  logic          out_load, load_last, load_rm;
  logic          out_valid_r;

  swlru_chain #(.ENTRIES(ENTRIES), .AW(AW), .IW(IW)) u_chain (
    .clk         (clk),
    .rst_n       (rst_n),
    .op          (chain_op),
    .pos         (chain_pos),
    .new_key     (key_r),
    .new_size    (amt_r),
    .search_key  (key_r),
    .hit_vec     (hit_vec),
    .key_at_pos  (key_at_pos),
    .size_at_pos (size_at_pos)
  );

  always_comb begin
    enc_pos = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit_vec[i]) enc_pos = IW'(i);
    end
  end

  assign size_ext = UW'(size_at_pos);
  assign used64   = 64'(used_r);
  assign cap64    = 64'(cap_r);
  assign amt64    = 64'(amt_r);
  assign ex_w     = hit_r ? ((size_ext > used_r) ? used_r : size_ext) : '0;
  assign ex64     = 64'(ex_w);
  assign need64   = used64 - ex64 + amt64;

  assign in_stall = (state_r != swlru_pkg::S_IDLE);
  assign out_load = (state_r == swlru_pkg::S_OUT) && (!out_valid_r || !out_stall);
  assign load_rm  = (idx_r < nres_r);
  assign load_last = load_rm ? ((idx_r + NW'(1) == nres_r) && (nres_r == NW'(MAXO))) : 1'b1;

  always_comb begin
    state_nxt    = state_r;
    act_nxt      = act_r;
    key_nxt      = key_r;
    amt_nxt      = amt_r;
    force_nxt    = force_r;
    erase_nxt    = erase_r;
    used_nxt     = used_r;
    cap_nxt      = cap_r;
    rm_cnt_nxt   = rm_cnt_r;
    ev_cnt_nxt   = ev_cnt_r;
    seq_base_nxt = seq_base_r;
    count_nxt    = count_r;
    hit_nxt      = hit_r;
    pos_nxt      = pos_r;
    status_nxt   = status_r;
    erased_nxt   = erased_r;
    sub_nxt      = sub_r;
    tgt_nxt      = tgt_r;
    minc_nxt     = minc_r;
    en_nxt       = en_r;
    nres_nxt     = nres_r;
    idx_nxt      = idx_r;
    chain_op     = swlru_pkg::CO_NONE;
    emit         = 1'b0;
    emit_evict   = 1'b0;
    emit_pos     = pos_r;

    case (state_r)
      swlru_pkg::S_IDLE: begin
        if (in_valid) begin
          act_nxt      = in_action;
          key_nxt      = in_entry_key;
          amt_nxt      = in_amount[AW-1:0];
          force_nxt    = in_force_req;
          erase_nxt    = in_erase_hint;
          status_nxt   = swlru_pkg::STAT_OK;
          erased_nxt   = 1'b0;
          nres_nxt     = '0;
          idx_nxt      = '0;
          seq_base_nxt = rm_cnt_r;
          state_nxt    = swlru_pkg::S_MATCH;
        end
      end
      swlru_pkg::S_MATCH: begin
        hit_nxt   = |hit_vec;
        pos_nxt   = enc_pos;
        state_nxt = swlru_pkg::S_ACT;
      end
      swlru_pkg::S_ACT: begin
        state_nxt = swlru_pkg::S_OUT;
        case (swlru_pkg::act_t'(act_r))
          swlru_pkg::ACT_RESERVE: begin
            if (!force_r && need64 > cap64) begin
              status_nxt = swlru_pkg::STAT_REJECT;
            end else begin
              if (hit_r) chain_op = swlru_pkg::CO_FRONT;
              sub_nxt   = ex_w;
              tgt_nxt   = (cap64 >= amt64) ? CW'(cap64 - amt64) : '0;
              minc_nxt  = hit_r;
              en_nxt    = (need64 > cap64);
              state_nxt = swlru_pkg::S_EVICT;
            end
          end
          swlru_pkg::ACT_REGISTER: begin
            if (hit_r) begin
              // old copy of the key leaves silently
              chain_op  = swlru_pkg::CO_REMOVE;
              used_nxt  = (used_r >= size_ext) ? used_r - size_ext : '0;
              count_nxt = count_r - CNTW'(1);
            end else if (count_r == CNTW'(ENTRIES)) begin
              emit       = 1'b1;
              emit_evict = 1'b1;
              emit_pos   = IW'(count_r - CNTW'(1));
            end
            state_nxt = swlru_pkg::S_INS;
          end
          swlru_pkg::ACT_TOUCH: begin
            if (!hit_r) begin
              status_nxt = swlru_pkg::STAT_MISS;
            end else if (erase_r) begin
              emit       = 1'b1;
              erased_nxt = 1'b1;
            end else begin
              chain_op = swlru_pkg::CO_FRONT;
            end
          end
          swlru_pkg::ACT_REMOVE: begin
            if (!hit_r) status_nxt = swlru_pkg::STAT_MISS;
            else emit = 1'b1;
          end
          swlru_pkg::ACT_SETCAP: begin
            cap_nxt   = CW'(amt_r);
            sub_nxt   = '0;
            tgt_nxt   = CW'(amt_r);
            minc_nxt  = 1'b0;
            en_nxt    = 1'b1;
            state_nxt = swlru_pkg::S_EVICT;
          end
          swlru_pkg::ACT_DEFLATE: begin
            cap_nxt   = (amt64 < cap64) ? CW'(cap64 - amt64) : '0;
            sub_nxt   = '0;
            tgt_nxt   = cap_nxt;
            minc_nxt  = 1'b0;
            en_nxt    = 1'b1;
            state_nxt = swlru_pkg::S_EVICT;
          end
          swlru_pkg::ACT_INFLATE: begin
            cap_nxt = (cap64 + amt64 > SzMask) ? CW'(SzMask) : CW'(cap64 + amt64);
          end
          default: ;
        endcase
      end
      swlru_pkg::S_INS: begin
        chain_op  = swlru_pkg::CO_INSERT;
        used_nxt  = used_r + UW'(amt_r);
        count_nxt = count_r + CNTW'(1);
        sub_nxt   = '0;
        tgt_nxt   = cap_r;
        minc_nxt  = 1'b0;
        en_nxt    = 1'b1;
        state_nxt = swlru_pkg::S_EVICT;
      end
      swlru_pkg::S_EVICT: begin
        // evict from the least recent end while over the byte target
        if (en_r && (used64 - 64'(sub_r) > 64'(tgt_r)) && (count_r > CNTW'(minc_r))) begin
          emit       = 1'b1;
          emit_evict = 1'b1;
          emit_pos   = IW'(count_r - CNTW'(1));
        end else begin
          idx_nxt   = '0;
          state_nxt = swlru_pkg::S_OUT;
        end
      end
      swlru_pkg::S_OUT: begin
        if (out_load) begin
          idx_nxt = idx_r + NW'(1);
          if (load_last) state_nxt = swlru_pkg::S_IDLE;
        end
      end
      default: state_nxt = swlru_pkg::S_IDLE;
    endcase

    if (emit) begin
      chain_op   = swlru_pkg::CO_REMOVE;
      rm_cnt_nxt = rm_cnt_r + 32'd1;
      if (emit_evict) ev_cnt_nxt = ev_cnt_r + 32'd1;
      used_nxt   = (used_r >= size_ext) ? used_r - size_ext : '0;
      count_nxt  = count_r - CNTW'(1);
      if (nres_r < NW'(MAXO)) nres_nxt = nres_r + NW'(1);
    end
  end

  assign chain_pos = emit ? emit_pos : pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= swlru_pkg::S_IDLE;
      used_r   <= '0;
      cap_r    <= '0;
      rm_cnt_r <= '0;
      ev_cnt_r <= '0;
      count_r  <= '0;
      nres_r   <= '0;
      idx_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      used_r   <= used_nxt;
      cap_r    <= cap_nxt;
      rm_cnt_r <= rm_cnt_nxt;
      ev_cnt_r <= ev_cnt_nxt;
      count_r  <= count_nxt;
      nres_r   <= nres_nxt;
      idx_r    <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    key_r      <= key_nxt;
    amt_r      <= amt_nxt;
    force_r    <= force_nxt;
    erase_r    <= erase_nxt;
    seq_base_r <= seq_base_nxt;
    hit_r      <= hit_nxt;
    pos_r      <= pos_nxt;
    status_r   <= status_nxt;
    erased_r   <= erased_nxt;
    sub_r      <= sub_nxt;
    tgt_r      <= tgt_nxt;
    minc_r     <= minc_nxt;
    en_r       <= en_nxt;
  end

  // removal words wait here until the final totals are known
  always_ff @(posedge clk) begin
    if (emit && nres_r < NW'(MAXO)) begin
      buf_key[nres_r[BIW-1:0]]  <= key_at_pos;
      buf_size[nres_r[BIW-1:0]] <= size_at_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_removed_valid <= load_rm;
      out_removed_key   <= load_rm ? buf_key[idx_r[BIW-1:0]] : 64'd0;
      out_removed_size  <= load_rm ? 40'(buf_size[idx_r[BIW-1:0]]) : 40'd0;
      out_removal_seq   <= load_rm ? seq_base_r + 32'(idx_r) : 32'd0;
      out_status        <= status_r;
      out_erased        <= erased_r;
      out_usage         <= 44'(used64);
      out_capacity_now  <= 40'(cap64);
      out_evicted_total <= ev_cnt_r;
      out_last          <= load_last;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire
